@@ design/nfba_pkg.sv @@
// Package for the next-fit block allocator: field widths, default sizes,
// action, status, type-map and sequencer state codes.
// No dependencies.
package nfba_pkg;

   localparam int ACTION_W = 2;
   localparam int LENGTH_W = 8;
   localparam int COUNT_W  = 6;
   localparam int BLOCK_W  = 7;
   localparam int STATUS_W = 2;
   localparam int MAP_W    = 2;

   localparam int NUM_BLOCKS_DEF      = 128;
   localparam int BYTES_PER_BLOCK_DEF = 4;
   localparam int MAX_RUN_DEF         = 63;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC     = 2'd0,
      ACT_GROW      = 2'd1,
      ACT_FREE_DATA = 2'd2,
      ACT_FREE_ANY  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_NOT_DATA = 2'd2
   } status_type;

   typedef enum logic [MAP_W-1:0] {
      MAP_FREE  = 2'd0,
      MAP_INDEX = 2'd1,
      MAP_DATA  = 2'd2
   } map_code_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SIZE,
      S_SCAN_START,
      S_SCAN,
      S_CLAIM,
      S_RB_READ,
      S_RB_FREE,
      S_FAIL,
      S_FREE_READ,
      S_FREE
   } state_type;

endpackage

@@ design/nfba_req_if.sv @@
// Request channel of the next-fit block allocator.
// Depends on nfba_pkg for the field widths.
interface nfba_req_if import nfba_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [LENGTH_W-1:0] length_bytes;
   logic [COUNT_W-1:0]  block_count;
   logic [BLOCK_W-1:0]  block;
   logic                last;

   modport source (output valid, action, length_bytes, block_count, block, last,
                   input ready);
   modport sink   (input valid, action, length_bytes, block_count, block, last,
                   output ready);
endinterface

@@ design/nfba_rsp_if.sv @@
// Response channel of the next-fit block allocator.
// Depends on nfba_pkg for the field widths.
interface nfba_rsp_if import nfba_pkg::*;;
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  out_block;
   logic                has_block;
   logic                block_kind;
   logic [STATUS_W-1:0] status;
   logic                last_result;

   modport source (output valid, out_block, has_block, block_kind, status, last_result,
                   input ready);
   modport sink   (input valid, out_block, has_block, block_kind, status, last_result,
                   output ready);
endinterface

@@ design/nfba_ram.sv @@
// Simple dual-port memory: one write port, one read port with registered data.
// Used for the block type map and the rollback list. No package dependency.
module nfba_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/next_fit_block_allocator_top.sv @@
// Next-fit block allocator. After reset all NUM_BLOCKS type-map entries are cleared,
// one per cycle, with req ready low. Free actions read, then update, the entry. Alloc
// sizes its run as ceil(length/BYTES_PER_BLOCK) data blocks (at most MAX_RUN) and
// claims an index block; each block is found by probing entries in turn, and a failing
// search probes NUM_BLOCKS entries, then frees each rolled-back block. The type-map read
// port sets the rate. Only one request is in flight; a finished beat may wait in the output.
module next_fit_block_allocator_top import nfba_pkg::*; #(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int BYTES_PER_BLOCK = BYTES_PER_BLOCK_DEF,
   parameter int MAX_RUN         = MAX_RUN_DEF
) (
   input logic        clock,
   input logic        reset,
   nfba_req_if.sink   req_bus,
   nfba_rsp_if.source rsp_bus
);

   localparam int AW       = $clog2(NUM_BLOCKS);
   localparam int RB_DEPTH = MAX_RUN + 1;
   localparam int RBW      = $clog2(RB_DEPTH);
   localparam int RBC      = $clog2(RB_DEPTH + 1);
   localparam int NW       = $clog2(MAX_RUN + 1);
   localparam int WW       = ((AW > BLOCK_W) ? AW : BLOCK_W) + 1;

   state_type           state_ff, state_in;
   logic [AW-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]       probe_ff, probe_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [NW-1:0]       need_ff, need_in;
   logic [LENGTH_W-1:0] rem_ff, rem_in;
   logic                index_ff, index_in;
   logic [RBC-1:0]      rb_cnt_ff, rb_cnt_in;
   logic [RBC-1:0]      rb_idx_ff, rb_idx_in;
   logic                free_failed_ff, free_failed_in;
   action_type          act_ff, act_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic                last_ff, last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]  rsp_block_ff, rsp_block_in;
   logic                rsp_has_ff, rsp_has_in;
   logic                rsp_kind_ff, rsp_kind_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                tm_we;
   logic [AW-1:0]       tm_waddr, tm_raddr;
   logic [MAP_W-1:0]    tm_wdata, tm_rdata;
   logic                rb_we;
   logic [RBW-1:0]      rb_waddr, rb_raddr;
   logic [AW-1:0]       rb_wdata, rb_rdata;

   logic                accept, can_emit, in_range;
   logic [AW-1:0]       ptr_next, blk_addr;
   logic [NW-1:0]       grow_need;

   nfba_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(MAP_W)) u_type_map (
      .clock   (clock),
      .wr_en   (tm_we),
      .wr_addr (tm_waddr),
      .wr_data (tm_wdata),
      .rd_addr (tm_raddr),
      .rd_data (tm_rdata)
   );

   nfba_ram #(.DEPTH(RB_DEPTH), .WIDTH(AW)) u_rollback (
      .clock   (clock),
      .wr_en   (rb_we),
      .wr_addr (rb_waddr),
      .wr_data (rb_wdata),
      .rd_addr (rb_raddr),
      .rd_data (rb_rdata)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && (state_ff == S_IDLE);
   assign can_emit      = !rsp_valid_ff || rsp_bus.ready;
   assign ptr_next      = (scan_ptr_ff == AW'(NUM_BLOCKS - 1)) ? '0 : scan_ptr_ff + 1'b1;
   assign blk_addr      = AW'(blk_ff);
   assign in_range      = WW'(blk_ff) < WW'(NUM_BLOCKS);
   assign grow_need     = (req_bus.block_count > COUNT_W'(MAX_RUN)) ? NW'(MAX_RUN)
                                                                    : NW'(req_bus.block_count);

   always_comb begin
      state_in       = state_ff;
      scan_ptr_in    = scan_ptr_ff;
      probe_in       = probe_ff;
      clr_in         = clr_ff;
      need_in        = need_ff;
      rem_in         = rem_ff;
      index_in       = index_ff;
      rb_cnt_in      = rb_cnt_ff;
      rb_idx_in      = rb_idx_ff;
      free_failed_in = free_failed_ff;
      act_in         = act_ff;
      blk_in         = blk_ff;
      last_in        = last_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_block_in   = rsp_block_ff;
      rsp_has_in     = rsp_has_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      tm_we    = 1'b0;
      tm_waddr = scan_ptr_ff;
      tm_wdata = MAP_FREE;
      tm_raddr = scan_ptr_ff;
      rb_we    = 1'b0;
      rb_waddr = rb_cnt_ff[RBW-1:0];
      rb_wdata = scan_ptr_ff;
      rb_raddr = rb_idx_ff[RBW-1:0];

      case (state_ff)
         S_CLEAR: begin
            tm_we    = 1'b1;
            tm_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in    = action_type'(req_bus.action);
               blk_in    = req_bus.block;
               last_in   = req_bus.last;
               rem_in    = req_bus.length_bytes;
               rb_cnt_in = '0;
               index_in  = (action_type'(req_bus.action) == ACT_ALLOC);
               case (action_type'(req_bus.action))
                  ACT_ALLOC: begin
                     need_in  = '0;
                     state_in = S_SIZE;
                  end
                  ACT_GROW: begin
                     need_in  = grow_need;
                     state_in = (grow_need == '0) ? S_IDLE : S_SCAN_START;
                  end
                  default: begin
                     state_in = S_FREE_READ;
                  end
               endcase
            end
         end
         S_SIZE: begin
            // Rounded-up block count by repeated subtraction, capped at the run limit.
            if ((rem_ff == '0) || (need_ff == NW'(MAX_RUN))) begin
               state_in = S_SCAN_START;
            end else begin
               need_in = need_ff + 1'b1;
               rem_in  = (rem_ff <= LENGTH_W'(BYTES_PER_BLOCK)) ? '0
                                                               : rem_ff - LENGTH_W'(BYTES_PER_BLOCK);
            end
         end
         S_SCAN_START: begin
            probe_in = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Read data belongs to the entry under the scan pointer; the next entry
            // is requested in the same cycle so that one entry is probed per cycle.
            if (tm_rdata == MAP_FREE) begin
               state_in = S_CLAIM;
            end else begin
               tm_raddr    = ptr_next;
               scan_ptr_in = ptr_next;
               probe_in    = probe_ff + 1'b1;
               if (probe_ff == AW'(NUM_BLOCKS - 1)) begin
                  rb_idx_in = '0;
                  state_in  = S_RB_READ;
               end
            end
         end
         S_CLAIM: begin
            if (can_emit) begin
               tm_we         = 1'b1;
               tm_wdata      = index_ff ? MAP_INDEX : MAP_DATA;
               rb_we         = 1'b1;
               rb_cnt_in     = rb_cnt_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_block_in  = BLOCK_W'(scan_ptr_ff);
               rsp_has_in    = 1'b1;
               rsp_kind_in   = !index_ff;
               rsp_status_in = STAT_OK;
               if (index_ff) begin
                  index_in    = 1'b0;
                  rsp_last_in = (need_ff == '0);
                  state_in    = (need_ff == '0) ? S_IDLE : S_SCAN_START;
               end else begin
                  need_in     = need_ff - 1'b1;
                  rsp_last_in = (need_ff == NW'(1));
                  state_in    = (need_ff == NW'(1)) ? S_IDLE : S_SCAN_START;
               end
            end
         end
         S_RB_READ: begin
            if (rb_idx_ff == rb_cnt_ff) begin
               state_in = S_FAIL;
            end else begin
               state_in = S_RB_FREE;
            end
         end
         S_RB_FREE: begin
            tm_we     = 1'b1;
            tm_waddr  = rb_rdata;
            rb_idx_in = rb_idx_ff + 1'b1;
            state_in  = S_RB_READ;
         end
         S_FAIL: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = '0;
               rsp_has_in    = 1'b0;
               rsp_kind_in   = 1'b0;
               rsp_status_in = STAT_NO_SPACE;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FREE_READ: begin
            tm_raddr = blk_addr;
            state_in = S_FREE;
         end
         S_FREE: begin
            tm_raddr = blk_addr;
            tm_waddr = blk_addr;
            if ((act_ff == ACT_FREE_DATA) && free_failed_ff) begin
               // The run has already failed: drop the beat quietly.
               free_failed_in = !last_ff;
               state_in       = S_IDLE;
            end else if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_block_in  = '0;
               rsp_has_in    = 1'b0;
               rsp_kind_in   = 1'b0;
               state_in      = S_IDLE;
               if (act_ff == ACT_FREE_DATA) begin
                  if (in_range && (tm_rdata == MAP_DATA)) begin
                     tm_we        = 1'b1;
                     rsp_block_in = blk_ff;
                     rsp_has_in   = 1'b1;
                     rsp_kind_in  = 1'b1;
                  end else begin
                     rsp_status_in  = STAT_NOT_DATA;
                     free_failed_in = !last_ff;
                  end
               end else if (in_range) begin
                  tm_we        = 1'b1;
                  rsp_block_in = blk_ff;
                  rsp_has_in   = 1'b1;
                  rsp_kind_in  = (tm_rdata == MAP_DATA);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         scan_ptr_ff    <= '0;
         clr_ff         <= '0;
         rb_cnt_ff      <= '0;
         rb_idx_ff      <= '0;
         free_failed_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_ptr_ff    <= scan_ptr_in;
         clr_ff         <= clr_in;
         rb_cnt_ff      <= rb_cnt_in;
         rb_idx_ff      <= rb_idx_in;
         free_failed_ff <= free_failed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      need_ff       <= need_in;
      rem_ff        <= rem_in;
      index_ff      <= index_in;
      act_ff        <= act_in;
      blk_ff        <= blk_in;
      last_ff       <= last_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_block   = rsp_block_ff;
   assign rsp_bus.has_block   = rsp_has_ff;
   assign rsp_bus.block_kind  = rsp_kind_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.last_result = rsp_last_ff;

endmodule

@@ design/nfba_checker.sv @@
// Port-level checks for the next-fit block allocator, bound to the top level.
// Depends on nfba_pkg for widths and status codes.
module nfba_checker import nfba_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BLOCK_W-1:0]  rsp_out_block,
   input logic                rsp_has_block,
   input logic                rsp_block_kind,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_last_result
);

   // The type map is swept after reset before any request beat is taken.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during the clearing pass");

   // A response beat that is held off keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_out_block)
         && $stable(rsp_has_block) && $stable(rsp_block_kind) && $stable(rsp_status)
         && $stable(rsp_last_result))
      else $error("response beat changed or dropped while held off");

   a_empty_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_block) |-> (rsp_out_block == '0) && !rsp_block_kind)
      else $error("block fields set on a beat without a block");

   // Error beats never carry a block and always close the request.
   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> !rsp_has_block && rsp_last_result)
      else $error("error beat carries a block or is not the final beat");

endmodule

bind next_fit_block_allocator_top nfba_checker u_nfba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_block   (rsp_bus.out_block),
   .rsp_has_block   (rsp_bus.has_block),
   .rsp_block_kind  (rsp_bus.block_kind),
   .rsp_status      (rsp_bus.status),
   .rsp_last_result (rsp_bus.last_result)
);

@@ test/nfba_tb_pkg.sv @@
`timescale 1ns / 1ps
// Request and grant beat types and the block-map scoreboard for the
// next-fit allocator testbench. Depends on nfba_pkg for widths and codes.
package nfba_tb_pkg;
   import nfba_pkg::*;

   typedef struct packed {
      action_type           act;
      logic [LENGTH_W-1:0]  length_bytes;
      logic [COUNT_W-1:0]   block_count;
      logic [BLOCK_W-1:0]   block;
      logic                 last;
   } block_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]   out_block;
      logic                 has_block;
      logic                 block_kind;
      status_type           status;
      logic                 last_result;
   } block_grant_type;

   class block_map_tracker;
      map_code_type         type_map [NUM_BLOCKS_DEF];
      int                   scan_ptr;
      bit                   free_run_failed;
      logic [BLOCK_W-1:0]   claimed_now [$];
      block_grant_type      expected_grants [$];
      int                   errors;

      function new();
         foreach (type_map[i]) type_map[i] = MAP_FREE;
         scan_ptr        = 0;
         free_run_failed = 1'b0;
         errors          = 0;
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      function int used_count();
         int used;
         used = 0;
         foreach (type_map[i]) if (type_map[i] != MAP_FREE) used++;
         return used;
      endfunction

      // Returns a block of the given kind from a random start, or the start if none.
      function int pick_block(map_code_type kind);
         int start;
         int b;
         start = $urandom_range(0, NUM_BLOCKS_DEF - 1);
         for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
            b = (start + i) % NUM_BLOCKS_DEF;
            if (type_map[b] == kind) return b;
         end
         return start;
      endfunction

      function void push_grant(int blk, bit has, bit kind, status_type st);
         block_grant_type g;
         g.out_block   = blk[BLOCK_W-1:0];
         g.has_block   = has;
         g.block_kind  = kind;
         g.status      = st;
         g.last_result = 1'b0;
         expected_grants.insert(expected_grants.size(), g);
      endfunction

      // Next-fit claim of one block. When nothing is free the whole request is
      // undone; the scan pointer keeps wherever the search left it.
      function bit claim_block(map_code_type kind);
         bit found;
         found = 1'b0;
         for (int i = 0; i < NUM_BLOCKS_DEF && !found; i++) begin
            if (type_map[scan_ptr] == MAP_FREE) found = 1'b1;
            else scan_ptr = (scan_ptr + 1) % NUM_BLOCKS_DEF;
         end
         if (!found) begin
            foreach (claimed_now[i]) type_map[claimed_now[i]] = MAP_FREE;
            claimed_now.delete();
            push_grant(0, 1'b0, 1'b0, STAT_NO_SPACE);
            return 1'b0;
         end
         type_map[scan_ptr] = kind;
         claimed_now.insert(claimed_now.size(), scan_ptr[BLOCK_W-1:0]);
         push_grant(scan_ptr, 1'b1, kind == MAP_DATA, STAT_OK);
         return 1'b1;
      endfunction

      // Predicts the grants of one accepted request and returns their number.
      function int note_request(block_req_type r);
         int base;
         int need;
         int n;
         bit kind;
         base = expected_grants.size();
         case (r.act)
            ACT_ALLOC, ACT_GROW: begin
               claimed_now.delete();
               if (r.act == ACT_ALLOC)
                  need = (int'(r.length_bytes) + BYTES_PER_BLOCK_DEF - 1) / BYTES_PER_BLOCK_DEF;
               else
                  need = int'(r.block_count);
               if (need > MAX_RUN_DEF) need = MAX_RUN_DEF;
               if (r.act == ACT_ALLOC && !claim_block(MAP_INDEX)) need = 0;
               for (int i = 0; i < need; i++)
                  if (!claim_block(MAP_DATA)) break;
               claimed_now.delete();
            end
            ACT_FREE_DATA: begin
               if (!free_run_failed) begin
                  if (type_map[r.block] == MAP_DATA) begin
                     type_map[r.block] = MAP_FREE;
                     push_grant(r.block, 1'b1, 1'b1, STAT_OK);
                  end else begin
                     free_run_failed = 1'b1;
                     push_grant(0, 1'b0, 1'b0, STAT_NOT_DATA);
                  end
               end
               if (r.last) free_run_failed = 1'b0;
            end
            default: begin
               kind = (type_map[r.block] == MAP_DATA);
               type_map[r.block] = MAP_FREE;
               push_grant(r.block, 1'b1, kind, STAT_OK);
            end
         endcase
         n = expected_grants.size() - base;
         if (n > 0) expected_grants[expected_grants.size() - 1].last_result = 1'b1;
         return n;
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_grant(block_grant_type got);
         block_grant_type exp;
         if (expected_grants.size() == 0) begin
            report_mismatch($sformatf("unexpected grant, block %0d status %0d",
                                      got.out_block, got.status));
            return;
         end
         exp = expected_grants.pop_front();
         if (got.out_block !== exp.out_block)
            report_mismatch($sformatf("out_block %0d, expected %0d",
                                      got.out_block, exp.out_block));
         if (got.has_block !== exp.has_block)
            report_mismatch($sformatf("has_block %b, expected %b",
                                      got.has_block, exp.has_block));
         if (got.block_kind !== exp.block_kind)
            report_mismatch($sformatf("block_kind %b, expected %b on block %0d",
                                      got.block_kind, exp.block_kind, exp.out_block));
         if (got.status !== exp.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
         if (got.last_result !== exp.last_result)
            report_mismatch($sformatf("last_result %b, expected %b",
                                      got.last_result, exp.last_result));
      endtask
   endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench for next_fit_block_allocator_top: directed and random
// requests with random idling on both channels, checked by block_map_tracker.
// Depends on nfba_pkg, nfba_req_if, nfba_rsp_if and nfba_tb_pkg.
module tb_top;
   import nfba_pkg::*;
   import nfba_tb_pkg::*;

   localparam int RANDOM_ITEMS     = 380;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 300;

   logic clock;
   logic reset;

   nfba_req_if req_bus ();
   nfba_rsp_if rsp_bus ();

   next_fit_block_allocator_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   block_map_tracker tracker = new();

   int tx_calm;
   int rx_calm;
   bit hold_rsp;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly a random idle gap, with the odd stretch of back-to-back beats.
   function automatic int draw_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(15, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic block_req_type make_req(action_type a, int len, int cnt, int blk,
                                              bit last);
      block_req_type r;
      r.act          = a;
      r.length_bytes = len[LENGTH_W-1:0];
      r.block_count  = cnt[COUNT_W-1:0];
      r.block        = blk[BLOCK_W-1:0];
      r.last         = last;
      return r;
   endfunction

   // Offers one beat, waits for it to be taken and predicts its grants. Valid
   // stays high when the next beat follows straight away.
   task automatic send(block_req_type r, output int n);
      int gap;
      req_bus.valid        <= 1'b1;
      req_bus.action       <= r.act;
      req_bus.length_bytes <= r.length_bytes;
      req_bus.block_count  <= r.block_count;
      req_bus.block        <= r.block;
      req_bus.last         <= r.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      n   = tracker.note_request(r);
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      int n;
      send(make_req(ACT_FREE_ANY, 0, 0, 0, 1'b0), n);     // free-any on a free block
      send(make_req(ACT_FREE_DATA, 0, 0, 5, 1'b0), n);    // not data: run fails
      send(make_req(ACT_FREE_DATA, 0, 0, 6, 1'b0), n);    // ignored
      send(make_req(ACT_FREE_DATA, 0, 0, 7, 1'b1), n);    // ignored, clears failure
      send(make_req(ACT_FREE_DATA, 0, 0, 9, 1'b1), n);    // not data on the last beat
      send(make_req(ACT_GROW, 255, 0, 127, 1'b1), n);     // zero-length grow
      send(make_req(ACT_ALLOC, 0, 63, 0, 1'b0), n);
      send(make_req(ACT_ALLOC, 1, 0, 0, 1'b0), n);
      send(make_req(ACT_ALLOC, 255, 0, 0, 1'b0), n);      // clamped to the longest run
      send(make_req(ACT_GROW, 0, 63, 0, 1'b0), n);        // runs out and rolls back
      send(make_req(ACT_ALLOC, 252, 0, 0, 1'b0), n);
      n = 128 - tracker.used_count();
      send(make_req(ACT_GROW, 0, (n > MAX_RUN_DEF) ? MAX_RUN_DEF : n, 0, 1'b0), n);
      send(make_req(ACT_ALLOC, 0, 0, 0, 1'b0), n);        // no index block left
      send(make_req(ACT_GROW, 0, 1, 0, 1'b0), n);
      send(make_req(ACT_FREE_DATA, 0, 0, tracker.pick_block(MAP_DATA), 1'b0), n);
      send(make_req(ACT_FREE_DATA, 0, 0, tracker.pick_block(MAP_INDEX), 1'b0), n);
      send(make_req(ACT_FREE_DATA, 0, 0, tracker.pick_block(MAP_DATA), 1'b1), n);
      send(make_req(ACT_FREE_ANY, 0, 0, tracker.pick_block(MAP_INDEX), 1'b0), n);
      send(make_req(ACT_FREE_ANY, 0, 0, tracker.pick_block(MAP_DATA), 1'b0), n);
      send(make_req(ACT_ALLOC, 5, 0, 0, 1'b0), n);
      send(make_req(ACT_FREE_ANY, 0, 0, 127, 1'b1), n);
      send(make_req(ACT_FREE_DATA, 0, 0, 127, 1'b1), n);
   endtask

   task automatic run_random();
      int sent;
      int n;
      int r;
      int runlen;
      int blk;
      bit held;
      bit paused;
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 120 && !held) begin
            held     = 1'b1;
            hold_rsp = 1'b1;
         end
         if (sent >= 250 && !paused) begin
            paused = 1'b1;
            pause_until_drained();
         end
         r = $urandom_range(0, 99);
         // A nearly full map is steered towards frees so that space keeps turning over.
         if (tracker.used_count() > 100 && r < 55) r += 45;
         if (r < 30) begin
            send(make_req(ACT_ALLOC,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 24),
                          $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 1)), n);
            sent++;
         end else if (r < 50) begin
            send(make_req(ACT_GROW, $urandom_range(0, 255),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 6),
                          $urandom_range(0, 127), $urandom_range(0, 1)), n);
            sent++;
         end else if (r < 85) begin
            runlen = $urandom_range(1, 4);
            for (int j = 0; j < runlen; j++) begin
               blk = ($urandom_range(0, 9) < 8) ? tracker.pick_block(MAP_DATA)
                                                : $urandom_range(0, 127);
               send(make_req(ACT_FREE_DATA, $urandom_range(0, 255), $urandom_range(0, 63),
                             blk, (j == runlen - 1) || ($urandom_range(0, 9) == 0)), n);
               if (n > 0) sent++;
            end
         end else begin
            if ($urandom_range(0, 9) < 7)
               blk = tracker.pick_block($urandom_range(0, 1) ? MAP_INDEX : MAP_DATA);
            else
               blk = $urandom_range(0, 127);
            send(make_req(ACT_FREE_ANY, $urandom_range(0, 255), $urandom_range(0, 63),
                          blk, $urandom_range(0, 1)), n);
            sent++;
         end
      end
   endtask

   // Result side: random stalls per beat, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rx_calm);
         if (hold_rsp) begin
            stall    = LONG_HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      block_grant_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.out_block   = rsp_bus.out_block;
         got.has_block   = rsp_bus.has_block;
         got.block_kind  = rsp_bus.block_kind;
         got.status      = status_type'(rsp_bus.status);
         got.last_result = rsp_bus.last_result;
         tracker.check_grant(got);
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_ALLOC;
      req_bus.length_bytes = '0;
      req_bus.block_count  = '0;
      req_bus.block        = '0;
      req_bus.last         = 1'b0;
      tx_calm              = 0;
      rx_calm              = 0;
      hold_rsp             = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      pause_until_drained();
      run_random();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
design/nfba_pkg.sv
design/nfba_req_if.sv
design/nfba_rsp_if.sv
design/nfba_ram.sv
design/next_fit_block_allocator_top.sv
design/nfba_checker.sv
test/nfba_tb_pkg.sv
test/tb_top.sv
